### src/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared types, character codes and the gamma table of the duty command parser.
// ----------------------------------------------------------------------------
package dcp_pkg;

    // Scan phases of one line
    typedef enum logic [3:0] {
        PH_LEAD   = 4'd0,
        PH_BAD    = 4'd1,
        PH_KEY    = 4'd2,
        PH_COLON  = 4'd3,
        PH_BLANK  = 4'd4,
        PH_SIGN   = 4'd5,
        PH_DIGITS = 4'd6,
        PH_DONE   = 4'd7,
        PH_FAIL   = 4'd8
    } t_phase;

    // Result status codes
    typedef enum logic [2:0] {
        ST_LEFT     = 3'd0,
        ST_RIGHT    = 3'd1,
        ST_STOP     = 3'd2,
        ST_NOT_JSON = 3'd3,
        ST_NO_VALUE = 3'd4
    } t_status;

    // Configuration register indexes
    localparam logic [1:0] CFG_LEFT_INV  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_INV = 2'd1;
    localparam logic [1:0] CFG_MIN_VIS   = 2'd2;

    localparam logic [7:0] MIN_VIS_RESET = 8'd2;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_KEY_L  = 8'h4C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Per-item summary from the line scanner
    typedef struct packed {
        logic       emit;
        t_status    status;
        logic [7:0] lin;
        logic       upd_left;
        logic       upd_right;
    } t_scan_res;

    // Gamma 2.2 table, entry i = round(255 * (i/255)^2.2), built exactly:
    // entry is the largest n with (2n-1)^5 * 255^6 <= 32 * i^11.
    function automatic logic [2047:0] gamma_build();
        logic [2047:0] rom;
        logic [127:0]  lhs;
        logic [127:0]  rhs;
        logic [8:0]    n;
        logic          done;
        rom = '0;
        n   = '0;
        for (int i = 0; i < 256; i++) begin
            lhs = 128'd32;
            for (int k = 0; k < 11; k++) begin
                lhs = lhs * 128'(i);
            end
            done = 1'b0;
            while (!done) begin
                if (n < 9'd255) begin
                    rhs = 128'd1;
                    for (int k = 0; k < 6; k++) begin
                        rhs = rhs * 128'd255;
                    end
                    for (int k = 0; k < 5; k++) begin
                        rhs = rhs * (128'(n) * 128'd2 + 128'd1);
                    end
                    if (rhs <= lhs) begin
                        n = n + 9'd1;
                    end else begin
                        done = 1'b1;
                    end
                end else begin
                    done = 1'b1;
                end
            end
            rom[i*8 +: 8] = n[7:0];
        end
        return rom;
    endfunction

    localparam logic [2047:0] GAMMA_ROM = gamma_build();

endpackage

### src/dcp_scan.sv
// ----------------------------------------------------------------------------
// dcp_scan
// Per-byte line scanner: tracks the parse state of the current line and, on
// LF, summarizes the line into a status and a normalized linear duty.
// ----------------------------------------------------------------------------
module dcp_scan #(
    parameter int LINE_BYTES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output dcp_pkg::t_scan_res  o_res
);

    localparam int CNT_W = $clog2(LINE_BYTES);

    logic [CNT_W-1:0] r_count, n_count;
    dcp_pkg::t_phase  r_phase, n_phase;
    logic [1:0]       r_key, n_key;
    logic             r_brace, n_brace;
    logic             r_neg, n_neg;
    logic             r_ended, n_ended;
    logic [8:0]       r_mag, n_mag;

    logic             is_digit;
    logic             is_blank;
    logic [3:0]       digit_val;
    logic [11:0]      mag_acc;
    logic [7:0]       lin;

    assign is_digit  = (i_byte >= dcp_pkg::CH_ZERO) && (i_byte <= dcp_pkg::CH_NINE);
    assign is_blank  = (i_byte == dcp_pkg::CH_SPACE) || (i_byte == dcp_pkg::CH_TAB);
    assign digit_val = 4'(i_byte - dcp_pkg::CH_ZERO);
    assign mag_acc   = 12'(r_mag) * 12'd10 + 12'(digit_val);

    // Normalize 0..127 to 0..255: (m*255+63)/127 equals 2m plus one when m >= 64
    always_comb begin
        if (r_mag <= 9'd127) begin
            lin = {r_mag[6:0], 1'b0} + {7'd0, r_mag[6]};
        end else if (r_mag > 9'd255) begin
            lin = 8'd255;
        end else begin
            lin = r_mag[7:0];
        end
    end

    // Summarize the line at LF
    always_comb begin
        o_res.emit      = (i_byte == dcp_pkg::CH_LF) && (r_count != '0);
        o_res.lin       = lin;
        o_res.upd_left  = 1'b0;
        o_res.upd_right = 1'b0;
        if (r_phase == dcp_pkg::PH_LEAD || r_phase == dcp_pkg::PH_BAD || !r_brace) begin
            o_res.status = dcp_pkg::ST_NOT_JSON;
        end else if (r_phase == dcp_pkg::PH_DIGITS || r_phase == dcp_pkg::PH_DONE) begin
            if (r_mag == '0) begin
                o_res.status    = dcp_pkg::ST_STOP;
                o_res.lin       = 8'd0;
                o_res.upd_left  = 1'b1;
                o_res.upd_right = 1'b1;
            end else if (!r_neg) begin
                o_res.status   = dcp_pkg::ST_LEFT;
                o_res.upd_left = 1'b1;
            end else begin
                o_res.status    = dcp_pkg::ST_RIGHT;
                o_res.upd_right = 1'b1;
            end
        end else begin
            o_res.status = dcp_pkg::ST_NO_VALUE;
        end
    end

    // Advance the line state by one byte
    always_comb begin
        n_count = r_count;
        n_phase = r_phase;
        n_key   = r_key;
        n_brace = r_brace;
        n_neg   = r_neg;
        n_ended = r_ended;
        n_mag   = r_mag;
        if (i_byte == dcp_pkg::CH_CR) begin
            n_count = r_count;
        end else if (i_byte == dcp_pkg::CH_LF
                     || r_count >= CNT_W'(LINE_BYTES - 1)) begin
            // end of line or overlong line: start over
            n_count = '0;
            n_phase = dcp_pkg::PH_LEAD;
            n_key   = 2'd0;
            n_brace = 1'b0;
            n_neg   = 1'b0;
            n_ended = 1'b0;
            n_mag   = '0;
        end else begin
            n_count = r_count + 1'b1;
            if (r_ended) begin
                n_ended = 1'b1;
            end else if (i_byte == dcp_pkg::CH_NUL) begin
                n_ended = 1'b1;
            end else begin
                if (i_byte == dcp_pkg::CH_RBRACE) begin
                    n_brace = 1'b1;
                end
                unique case (r_phase)
                    dcp_pkg::PH_LEAD: begin
                        if (!is_blank) begin
                            n_phase = (i_byte == dcp_pkg::CH_LBRACE) ? dcp_pkg::PH_KEY
                                                                     : dcp_pkg::PH_BAD;
                        end
                    end
                    dcp_pkg::PH_KEY: begin
                        priority if (r_key == 2'd0) begin
                            if (i_byte == dcp_pkg::CH_QUOTE) begin
                                n_key = 2'd1;
                            end
                        end else if (r_key == 2'd1) begin
                            if (i_byte == dcp_pkg::CH_KEY_L) begin
                                n_key = 2'd2;
                            end else if (i_byte != dcp_pkg::CH_QUOTE) begin
                                n_key = 2'd0;
                            end
                        end else begin
                            if (i_byte == dcp_pkg::CH_QUOTE) begin
                                n_phase = dcp_pkg::PH_COLON;
                            end
                            n_key = 2'd0;
                        end
                    end
                    dcp_pkg::PH_COLON: begin
                        if (i_byte == dcp_pkg::CH_COLON) begin
                            n_phase = dcp_pkg::PH_BLANK;
                        end
                    end
                    dcp_pkg::PH_BLANK: begin
                        if (!is_blank) begin
                            priority if (i_byte == dcp_pkg::CH_MINUS) begin
                                n_neg   = 1'b1;
                                n_phase = dcp_pkg::PH_SIGN;
                            end else if (i_byte == dcp_pkg::CH_PLUS) begin
                                n_phase = dcp_pkg::PH_SIGN;
                            end else if (is_digit) begin
                                n_mag   = 9'(digit_val);
                                n_phase = dcp_pkg::PH_DIGITS;
                            end else begin
                                n_phase = dcp_pkg::PH_FAIL;
                            end
                        end
                    end
                    dcp_pkg::PH_SIGN: begin
                        if (is_digit) begin
                            n_mag   = 9'(digit_val);
                            n_phase = dcp_pkg::PH_DIGITS;
                        end else begin
                            n_phase = dcp_pkg::PH_FAIL;
                        end
                    end
                    dcp_pkg::PH_DIGITS: begin
                        if (is_digit) begin
                            // saturate the magnitude at 256
                            n_mag = (mag_acc > 12'd256) ? 9'd256 : mag_acc[8:0];
                        end else begin
                            n_phase = dcp_pkg::PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // Line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= dcp_pkg::PH_LEAD;
            r_key   <= 2'd0;
            r_brace <= 1'b0;
            r_neg   <= 1'b0;
            r_ended <= 1'b0;
            r_mag   <= '0;
        end else if (i_step) begin
            r_count <= n_count;
            r_phase <= n_phase;
            r_key   <= n_key;
            r_brace <= n_brace;
            r_neg   <= n_neg;
            r_ended <= n_ended;
            r_mag   <= n_mag;
        end
    end

endmodule

### src/dcp_duty.sv
// ----------------------------------------------------------------------------
// dcp_duty
// One side's duty path: gamma table, minimum-visible clamp, optional inversion.
// ----------------------------------------------------------------------------
module dcp_duty (
    input  logic [7:0] i_lin,
    input  logic       i_invert,
    input  logic [7:0] i_min_visible,
    output logic [7:0] o_duty,
    output logic       o_enable
);

    logic [7:0] gamma;
    logic [7:0] clamped;

    // Look up the gamma curve
    assign gamma = dcp_pkg::GAMMA_ROM[{i_lin, 3'b000} +: 8];

    // Raise small nonzero outputs to the visible minimum
    always_comb begin
        if (i_lin == 8'd0) begin
            clamped = 8'd0;
        end else if (gamma != 8'd0 && gamma < i_min_visible) begin
            clamped = i_min_visible;
        end else begin
            clamped = gamma;
        end
    end

    assign o_duty   = i_invert ? ~clamped : clamped;
    assign o_enable = (i_lin != 8'd0);

endmodule

### src/signed_duty_command_parser_top.sv
// ----------------------------------------------------------------------------
// signed_duty_command_parser_top
// Parses {"L": <signed int>} lines from a byte stream into left/right duties.
// ----------------------------------------------------------------------------
// An LF goes through the input register, then its result is registered.
// Throughput: one byte per cycle; the input register holds a byte only while
//   it ends a non-empty line and the result register is not yet taken.
// Reset: synchronous active-low; clears the line state, the held duties and
//   enables, and loads the configuration defaults (no inversion, minimum 2).
module signed_duty_command_parser_top #(
    parameter int LINE_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [2:0] o_status,
    output logic [7:0] o_left_duty,
    output logic       o_left_enable,
    output logic [7:0] o_right_duty,
    output logic       o_right_enable,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_left_inv;
    logic               r_right_inv;
    logic [7:0]         r_min_vis;
    logic [7:0]         r_left_duty, n_left_duty;
    logic               r_left_en, n_left_en;
    logic [7:0]         r_right_duty, n_right_duty;
    logic               r_right_en, n_right_en;
    logic               r_out_valid;
    logic [2:0]         r_out_status;

    logic               advance;
    dcp_pkg::t_scan_res scan_res;
    logic [7:0]         left_duty_new;
    logic               left_en_new;
    logic [7:0]         right_duty_new;
    logic               right_en_new;

    // Move the held byte on unless its result has nowhere to go
    assign advance    = r_in_valid && (!scan_res.emit || !r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_inv  <= 1'b0;
            r_right_inv <= 1'b0;
            r_min_vis   <= dcp_pkg::MIN_VIS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dcp_pkg::CFG_LEFT_INV:  r_left_inv  <= i_cfg_data[0];
                dcp_pkg::CFG_RIGHT_INV: r_right_inv <= i_cfg_data[0];
                dcp_pkg::CFG_MIN_VIS:   r_min_vis   <= i_cfg_data;
                default:                r_min_vis   <= r_min_vis;
            endcase
        end
    end

    dcp_scan #(
        .LINE_BYTES (LINE_BYTES)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_res   (scan_res)
    );

    dcp_duty u_left (
        .i_lin         (scan_res.lin),
        .i_invert      (r_left_inv),
        .i_min_visible (r_min_vis),
        .o_duty        (left_duty_new),
        .o_enable      (left_en_new)
    );

    dcp_duty u_right (
        .i_lin         (scan_res.lin),
        .i_invert      (r_right_inv),
        .i_min_visible (r_min_vis),
        .o_duty        (right_duty_new),
        .o_enable      (right_en_new)
    );

    // Select the side outputs after this line's update
    always_comb begin
        n_left_duty  = r_left_duty;
        n_left_en    = r_left_en;
        n_right_duty = r_right_duty;
        n_right_en   = r_right_en;
        if (scan_res.emit && scan_res.upd_left) begin
            n_left_duty = left_duty_new;
            n_left_en   = left_en_new;
        end
        if (scan_res.emit && scan_res.upd_right) begin
            n_right_duty = right_duty_new;
            n_right_en   = right_en_new;
        end
    end

    // Held side outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_duty  <= 8'd0;
            r_left_en    <= 1'b0;
            r_right_duty <= 8'd0;
            r_right_en   <= 1'b0;
        end else if (advance) begin
            r_left_duty  <= n_left_duty;
            r_left_en    <= n_left_en;
            r_right_duty <= n_right_duty;
            r_right_en   <= n_right_en;
        end
    end

    // Result register: load on a finished line, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && scan_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && scan_res.emit) begin
            r_out_status <= scan_res.status;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_left_duty    = r_left_duty;
    assign o_left_enable  = r_left_en;
    assign o_right_duty   = r_right_duty;
    assign o_right_enable = r_right_en;

endmodule

### src/dcp_checker.sv
// ----------------------------------------------------------------------------
// dcp_checker
// Port-level checks on the result channel of the duty command parser.
// ----------------------------------------------------------------------------
module dcp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_res_valid,
    input logic       i_res_ready,
    input logic [2:0] o_status,
    input logic [7:0] o_left_duty,
    input logic       o_left_enable,
    input logic [7:0] o_right_duty,
    input logic       o_right_enable
);

    // Hold a stalled result transaction
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_status)
            && $stable(o_left_duty) && $stable(o_right_duty)
            && $stable(o_left_enable) && $stable(o_right_enable))
        else $error("stalled result changed");

    // Stop drops both enables
    a_stop_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status == dcp_pkg::ST_STOP |-> !o_left_enable && !o_right_enable)
        else $error("stop result left a side enabled");

    // A left command enables the left side
    a_left_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status == dcp_pkg::ST_LEFT |-> o_left_enable)
        else $error("left result without left enable");

    // A right command enables the right side
    a_right_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status == dcp_pkg::ST_RIGHT |-> o_right_enable)
        else $error("right result without right enable");

endmodule

bind signed_duty_command_parser_top dcp_checker u_dcp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_res_valid    (o_res_valid),
    .i_res_ready    (i_res_ready),
    .o_status       (o_status),
    .o_left_duty    (o_left_duty),
    .o_left_enable  (o_left_enable),
    .o_right_duty   (o_right_duty),
    .o_right_enable (o_right_enable)
);
